// ===== rtl/core/svpid_pkg.sv =====
// Shared constants, types and helpers of the servo position PID block.
`default_nettype none

package svpid_pkg;

    // Fixed-point setup
    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int PW_W       = 15;
    localparam int SAMP_W     = 12;
    localparam int DUTY_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths
    localparam int ST_W     = 32;                         // Q16.16 state words
    localparam int WIDE_W   = 37;                         // filter sums, error diff
    localparam int DVD_W    = 36;                         // divider dividend / quotient
    localparam int DIV_W    = (ADC_BITS > 7) ? ADC_BITS : 7;
    localparam int STEP_W   = 4;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 23;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int MAG_SH   = FRAC_BITS + 12;

    // Divider steps (four quotient bits per step)
    localparam logic [STEP_W-1:0] TGT_STEPS  = STEP_W'(3);
    localparam logic [STEP_W-1:0] POS_STEPS  = STEP_W'((ADC_BITS + 8 + 3) / 4);
    localparam logic [STEP_W-1:0] FILT_STEPS = STEP_W'(DVD_W / 4);
    localparam logic [STEP_W-1:0] ISUM_STEPS = STEP_W'(ST_W / 4);
    localparam logic [STEP_W-1:0] DUTY_STEPS = STEP_W'(5);

    // Constant divisors
    localparam logic [DIV_W-1:0] DIV_TGT  = DIV_W'(5);
    localparam logic [DIV_W-1:0] DIV_POS  = DIV_W'((1 << ADC_BITS) - 1);
    localparam logic [DIV_W-1:0] DIV_FILT = DIV_W'(10);
    localparam logic [DIV_W-1:0] DIV_ISUM = DIV_W'(50);
    localparam logic [DIV_W-1:0] DIV_DUTY = DIV_W'(100);

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_P_RST = GAIN_W'(16384);
    localparam logic [GAIN_W-1:0]  GAIN_I_RST = GAIN_W'(82);
    localparam logic [GAIN_W-1:0]  GAIN_D_RST = GAIN_W'(1229);
    localparam logic [DUTY_W-1:0]  FLOOR_RST  = DUTY_W'(46);
    localparam logic [DUTY_W-1:0]  CEIL_RST   = DUTY_W'(191);
    localparam logic [LIMIT_W-1:0] LOW_RST    = LIMIT_W'(10);
    localparam logic [LIMIT_W-1:0] HIGH_RST   = LIMIT_W'(4080);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_DRIVE_FLOOR = 3'd3,
        CFG_DRIVE_CEIL  = 3'd4,
        CFG_SENSOR_LOW  = 3'd5,
        CFG_SENSOR_HIGH = 3'd6
    } cfg_idx_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_TGT_GO,
        UOP_TGT_END,
        UOP_POS_GO,
        UOP_POS_END,
        UOP_FT_GO,
        UOP_FT_END,
        UOP_FP_GO,
        UOP_FP_END,
        UOP_ERR,
        UOP_ISUM_GO,
        UOP_ISUM_END,
        UOP_MUL_P,
        UOP_MUL_I,
        UOP_MUL_D,
        UOP_MUL_ACC,
        UOP_MAG_GO,
        UOP_DUTY_END,
        UOP_EMIT
    } uop_t;

    typedef struct packed {
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic fault;
        logic out_free;
    } dp_status_t;

    // Saturate a wide signed value to the 32 bit state range
    function automatic logic signed [ST_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'({1'b0, {(ST_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            sat32 = {1'b0, {(ST_W-1){1'b1}}};
        end else if (v < lo) begin
            sat32 = {1'b1, {(ST_W-1){1'b0}}};
        end else begin
            sat32 = ST_W'(v);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/svpid_tick_if.sv =====
// Input channel: one control tick item per transfer.
`default_nettype none

interface svpid_tick_if;
    import svpid_pkg::*;

    logic              valid;
    logic              ready;
    logic [PW_W-1:0]   pulse_width;
    logic [SAMP_W-1:0] sensor_sample;

    modport source (output valid, output pulse_width, output sensor_sample, input ready);
    modport sink   (input valid, input pulse_width, input sensor_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/svpid_drive_if.sv =====
// Output channel: one motor drive item per tick.
`default_nettype none

interface svpid_drive_if;
    import svpid_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] forward_duty;
    logic [DUTY_W-1:0] reverse_duty;
    logic              sensor_fault;

    modport source (output valid, output forward_duty, output reverse_duty,
                    output sensor_fault, input ready);
    modport sink   (input valid, input forward_duty, input reverse_duty,
                    input sensor_fault, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/svpid_cdiv.sv =====
// Radix-16 restoring divider for small constant divisors, unsigned.
`default_nettype none

module svpid_cdiv (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [svpid_pkg::DVD_W-1:0]         dividend,
    input  logic [svpid_pkg::DIV_W-1:0]         divisor,
    input  logic [svpid_pkg::STEP_W-1:0]        steps,
    output logic                                done,
    output logic [svpid_pkg::DVD_W-1:0]         quotient
);
    import svpid_pkg::*;

    localparam int SH_W = $clog2(DVD_W + 1);

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [SH_W-1:0]   align_sh;
    logic [DIV_W:0]    rw;
    logic [3:0]        qd;

    // Left-align the dividend so that only the requested steps run
    assign align_sh = SH_W'(DVD_W) - SH_W'({steps, 2'b00});

    // Four restoring bit steps per cycle
    always_comb
    begin
        rw = {1'b0, rem_reg};
        qd = '0;
        for (int b = 0; b < 4; b++)
        begin
            rw = {rw[DIV_W-1:0], dvd_reg[DVD_W-1-b]};
            if (rw >= {1'b0, dsr_reg})
            begin
                rw        = rw - {1'b0, dsr_reg};
                qd[3-b]   = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = steps;
            dvd_next = dividend << align_sh;
            quo_next = '0;
            rem_next = '0;
            dsr_next = divisor;
        end else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
            dvd_next  = {dvd_reg[DVD_W-5:0], 4'b0000};
            quo_next  = {quo_reg[DVD_W-5:0], qd};
            rem_next  = rw[DIV_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/svpid_datapath.sv =====
// Datapath: registers, state, shared divider, multiplier and output register.
`default_nettype none

module svpid_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  svpid_pkg::dp_cmd_t                 cmd,
    output svpid_pkg::dp_status_t              status,
    input  logic [svpid_pkg::PW_W-1:0]         pulse_width,
    input  logic [svpid_pkg::SAMP_W-1:0]       sensor_sample,
    input  logic                               cfg_we,
    input  logic [svpid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svpid_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               drive_ready,
    output logic                               drive_valid,
    output logic [svpid_pkg::DUTY_W-1:0]       forward_duty,
    output logic [svpid_pkg::DUTY_W-1:0]       reverse_duty,
    output logic                               sensor_fault
);
    import svpid_pkg::*;

    localparam int SX_W = (ADC_BITS > SAMP_W) ? ADC_BITS : SAMP_W;
    localparam logic [SX_W-1:0]          ADC_MAX  = SX_W'((1 << ADC_BITS) - 1);
    localparam logic signed [ST_W-1:0]   ST_ONE   = ST_W'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] ISUM_LIM = WIDE_W'(100) << FRAC_BITS;

    // Configuration registers
    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DUTY_W-1:0]  floor_reg, ceil_reg;
    logic [LIMIT_W-1:0] low_reg, high_reg;

    // Item and working registers
    logic [PW_W-1:0]          pw_reg;
    logic [SAMP_W-1:0]        samp_reg;
    logic signed [7:0]        tgt_reg, pos_reg;
    logic signed [ST_W-1:0]   e_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     div_neg_reg;
    logic [DUTY_W-1:0]        res_fwd_reg, res_rev_reg;
    logic                     res_fault_reg;
    logic [DUTY_W-1:0]        out_fwd_reg, out_rev_reg;
    logic                     out_fault_reg;
    logic                     out_valid_reg;

    // Controller state kept across items
    logic signed [ST_W-1:0]   st_reg, sp_reg, esum_reg, prev_reg;

    // Divider hookup
    logic                     div_start;
    logic                     div_neg;
    logic [DVD_W-1:0]         div_dividend;
    logic [DIV_W-1:0]         div_divisor;
    logic [STEP_W-1:0]        div_steps;
    logic                     div_done;
    logic [DVD_W-1:0]         quo;
    logic signed [WIDE_W-1:0] qs;

    // Combinational helpers
    logic                     pw_in_range;
    logic signed [15:0]       pw_diff;
    logic [10:0]              pw_mag;
    logic signed [9:0]        tgt_wide, pos_wide;
    logic [SX_W-1:0]          samp_x, samp_c;
    logic [DVD_W-1:0]         pos_dvd;
    logic signed [ST_W-1:0]   filt_s;
    logic signed [7:0]        filt_x;
    logic signed [WIDE_W-1:0] filt_sum;
    logic                     filt_neg;
    logic [DVD_W-1:0]         filt_mag;
    logic signed [ST_W-1:0]   e_sat, e_db;
    logic                     deadband;
    logic                     fault_now;
    logic [ST_W-1:0]          e_abs;
    logic signed [WIDE_W-1:0] esum_sum;
    logic signed [ST_W-1:0]   esum_upd;
    logic [21:0]              gd50;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     acc_neg, acc_pos;
    logic [ACC_W-1:0]         acc_abs, acc_shr;
    logic [9:0]               mag_sat;
    logic [17:0]              mag255;
    logic [11:0]              m_val;
    logic [DUTY_W-1:0]        duty;

    // Shared constant divider
    svpid_cdiv u_cdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (quo)
    );

    assign qs = div_neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    // Target: (pw - 1000) / 5 toward zero, minus 100
    assign pw_in_range = (pw_reg > PW_W'(900)) && (pw_reg < PW_W'(2100));
    assign pw_diff     = $signed({1'b0, pw_reg}) - 16'sd1000;
    assign pw_mag      = 11'(pw_diff[15] ? -pw_diff : pw_diff);
    assign tgt_wide    = 10'(qs) - 10'sd100;

    // Position: clamp(sample) * 200 / ADC_MAX - 100
    assign samp_x  = SX_W'(samp_reg);
    assign samp_c  = (samp_x > ADC_MAX) ? ADC_MAX : samp_x;
    assign pos_dvd = (DVD_W'(samp_c) << 7) + (DVD_W'(samp_c) << 6) + (DVD_W'(samp_c) << 3);
    assign pos_wide = $signed({2'b00, quo[7:0]}) - 10'sd100;

    // Filter: 9*s + x*ONE, divided by 10 toward zero
    assign filt_s   = (cmd.uop == UOP_FP_GO) ? sp_reg : st_reg;
    assign filt_x   = (cmd.uop == UOP_FP_GO) ? pos_reg : tgt_reg;
    assign filt_sum = (WIDE_W'(filt_s) <<< 3) + WIDE_W'(filt_s)
                    + (WIDE_W'(filt_x) <<< FRAC_BITS);
    assign filt_neg = filt_sum[WIDE_W-1];
    assign filt_mag = DVD_W'(filt_neg ? -filt_sum : filt_sum);

    // Error with deadband, sensor limits
    assign e_sat     = sat32(WIDE_W'(st_reg) - WIDE_W'(sp_reg));
    assign deadband  = (e_sat > -ST_ONE) && (e_sat < ST_ONE);
    assign e_db      = deadband ? '0 : e_sat;
    assign fault_now = (samp_reg < low_reg) || (samp_reg > high_reg);
    assign e_abs     = ST_W'(e_reg[ST_W-1] ? -e_reg : e_reg);

    // Integral update, held to +-100
    assign esum_sum = WIDE_W'(esum_reg) + qs;
    always_comb
    begin
        if (esum_sum > ISUM_LIM)
        begin
            esum_upd = ST_W'(ISUM_LIM);
        end else if (esum_sum < -ISUM_LIM)
        begin
            esum_upd = ST_W'(-ISUM_LIM);
        end else
        begin
            esum_upd = ST_W'(esum_sum);
        end
    end

    // Shared multiplier; derivative folded as (e - prev) * (gain_d * 50)
    assign gd50 = (22'(gain_d_reg) << 5) + (22'(gain_d_reg) << 4) + (22'(gain_d_reg) << 1);
    always_comb
    begin
        case (cmd.uop)
            UOP_MUL_I:
            begin
                mul_a = MUL_A_W'(esum_reg);
                mul_b = $signed({7'b0, gain_i_reg});
            end
            UOP_MUL_D:
            begin
                mul_a = MUL_A_W'(e_reg) - MUL_A_W'(prev_reg);
                mul_b = $signed({1'b0, gd50});
            end
            default:
            begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = $signed({7'b0, gain_p_reg});
            end
        endcase
    end
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Output magnitude and duty mapping
    assign acc_neg = acc_reg[ACC_W-1];
    assign acc_pos = !acc_reg[ACC_W-1] && (acc_reg != '0);
    assign acc_abs = ACC_W'(acc_neg ? -acc_reg : acc_reg);
    assign acc_shr = acc_abs >> MAG_SH;
    assign mag_sat = (acc_shr > ACC_W'(1000)) ? 10'd1000 : acc_shr[9:0];
    assign mag255  = {mag_sat, 8'b0} - 18'(mag_sat);
    assign m_val   = quo[11:0];
    always_comb
    begin
        if (m_val == '0)
        begin
            duty = '0;
        end else if (m_val < 12'(floor_reg))
        begin
            duty = floor_reg;
        end else if (m_val > 12'(ceil_reg))
        begin
            duty = ceil_reg;
        end else
        begin
            duty = m_val[DUTY_W-1:0];
        end
    end

    // Divider operand select
    always_comb
    begin
        div_start    = 1'b1;
        div_neg      = 1'b0;
        div_dividend = '0;
        div_divisor  = DIV_FILT;
        div_steps    = FILT_STEPS;
        case (cmd.uop)
            UOP_TGT_GO:
            begin
                div_dividend = pw_in_range ? DVD_W'(pw_mag) : '0;
                div_divisor  = DIV_TGT;
                div_steps    = TGT_STEPS;
                div_neg      = pw_diff[15];
            end
            UOP_POS_GO:
            begin
                div_dividend = pos_dvd;
                div_divisor  = DIV_W'(ADC_MAX);
                div_steps    = POS_STEPS;
            end
            UOP_FT_GO, UOP_FP_GO:
            begin
                div_dividend = filt_mag;
                div_neg      = filt_neg;
            end
            UOP_ISUM_GO:
            begin
                div_dividend = DVD_W'(e_abs);
                div_divisor  = DIV_ISUM;
                div_steps    = ISUM_STEPS;
                div_neg      = e_reg[ST_W-1];
            end
            UOP_MAG_GO:
            begin
                div_dividend = DVD_W'(mag255);
                div_divisor  = DIV_DUTY;
                div_steps    = DUTY_STEPS;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RST;
            gain_i_reg <= GAIN_I_RST;
            gain_d_reg <= GAIN_D_RST;
            floor_reg  <= FLOOR_RST;
            ceil_reg   <= CEIL_RST;
            low_reg    <= LOW_RST;
            high_reg   <= HIGH_RST;
        end else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_P:      gain_p_reg <= cfg_data;
                CFG_GAIN_I:      gain_i_reg <= cfg_data;
                CFG_GAIN_D:      gain_d_reg <= cfg_data;
                CFG_DRIVE_FLOOR: floor_reg  <= cfg_data[DUTY_W-1:0];
                CFG_DRIVE_CEIL:  ceil_reg   <= cfg_data[DUTY_W-1:0];
                CFG_SENSOR_LOW:  low_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_SENSOR_HIGH: high_reg   <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Filter, integral and derivative state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            sp_reg   <= '0;
            esum_reg <= '0;
            prev_reg <= '0;
        end else
        begin
            case (cmd.uop)
                UOP_FT_END:   st_reg <= sat32(qs);
                UOP_FP_END:   sp_reg <= sat32(qs);
                UOP_ERR:
                begin
                    if (deadband || fault_now)
                    begin
                        esum_reg <= '0;
                    end
                    if (fault_now)
                    begin
                        prev_reg <= e_db;
                    end
                end
                UOP_ISUM_END: esum_reg <= esum_upd;
                UOP_MUL_D:    prev_reg <= e_reg;
                default:      ;
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (cmd.uop == UOP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end else if (drive_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Item and working payload
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_neg_reg <= div_neg;
        end
        case (cmd.uop)
            UOP_LOAD:
            begin
                pw_reg   <= pulse_width;
                samp_reg <= sensor_sample;
            end
            UOP_TGT_END:  tgt_reg <= pw_in_range ? 8'(tgt_wide) : '0;
            UOP_POS_END:  pos_reg <= 8'(pos_wide);
            UOP_ERR:
            begin
                e_reg         <= e_db;
                res_fwd_reg   <= '0;
                res_rev_reg   <= '0;
                res_fault_reg <= 1'b1;
            end
            UOP_MUL_P:    prod_reg <= mul_prod;
            UOP_MUL_I:
            begin
                prod_reg <= mul_prod;
                acc_reg  <= ACC_W'(prod_reg);
            end
            UOP_MUL_D:
            begin
                prod_reg <= mul_prod;
                acc_reg  <= acc_reg + ACC_W'(prod_reg);
            end
            UOP_MUL_ACC:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            UOP_DUTY_END:
            begin
                res_fwd_reg   <= acc_pos ? duty : '0;
                res_rev_reg   <= acc_neg ? duty : '0;
                res_fault_reg <= 1'b0;
            end
            UOP_EMIT:
            begin
                out_fwd_reg   <= res_fwd_reg;
                out_rev_reg   <= res_rev_reg;
                out_fault_reg <= res_fault_reg;
            end
            default: ;
        endcase
    end

    assign status.div_done = div_done;
    assign status.fault    = fault_now;
    assign status.out_free = !out_valid_reg || drive_ready;

    assign drive_valid  = out_valid_reg;
    assign forward_duty = out_fwd_reg;
    assign reverse_duty = out_rev_reg;
    assign sensor_fault = out_fault_reg;

endmodule

`default_nettype wire

// ===== rtl/core/svpid_ctrl.sv =====
// Controller: sequences one tick through the datapath.
`default_nettype none

module svpid_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_ready,
    input  svpid_pkg::dp_status_t  status,
    output svpid_pkg::dp_cmd_t     cmd
);
    import svpid_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_TGT    = 19'h00002,
        S_TGT_W  = 19'h00004,
        S_POS    = 19'h00008,
        S_POS_W  = 19'h00010,
        S_FT     = 19'h00020,
        S_FT_W   = 19'h00040,
        S_FP     = 19'h00080,
        S_FP_W   = 19'h00100,
        S_ERR    = 19'h00200,
        S_ISUM   = 19'h00400,
        S_ISUM_W = 19'h00800,
        S_MP     = 19'h01000,
        S_MI     = 19'h02000,
        S_MD     = 19'h04000,
        S_MACC   = 19'h08000,
        S_MAG    = 19'h10000,
        S_MAG_W  = 19'h20000,
        S_EMIT   = 19'h40000
    } state_t;

    state_t state_reg, state_next;
    uop_t   uop;

    // Next state and micro-op
    always_comb
    begin
        state_next = state_reg;
        uop        = UOP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    uop        = UOP_LOAD;
                    state_next = S_TGT;
                end
            end
            S_TGT:
            begin
                uop        = UOP_TGT_GO;
                state_next = S_TGT_W;
            end
            S_TGT_W:
            begin
                if (status.div_done)
                begin
                    uop        = UOP_TGT_END;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                uop        = UOP_POS_GO;
                state_next = S_POS_W;
            end
            S_POS_W:
            begin
                if (status.div_done)
                begin
                    uop        = UOP_POS_END;
                    state_next = S_FT;
                end
            end
            S_FT:
            begin
                uop        = UOP_FT_GO;
                state_next = S_FT_W;
            end
            S_FT_W:
            begin
                if (status.div_done)
                begin
                    uop        = UOP_FT_END;
                    state_next = S_FP;
                end
            end
            S_FP:
            begin
                uop        = UOP_FP_GO;
                state_next = S_FP_W;
            end
            S_FP_W:
            begin
                if (status.div_done)
                begin
                    uop        = UOP_FP_END;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                uop        = UOP_ERR;
                state_next = status.fault ? S_EMIT : S_ISUM;
            end
            S_ISUM:
            begin
                uop        = UOP_ISUM_GO;
                state_next = S_ISUM_W;
            end
            S_ISUM_W:
            begin
                if (status.div_done)
                begin
                    uop        = UOP_ISUM_END;
                    state_next = S_MP;
                end
            end
            S_MP:
            begin
                uop        = UOP_MUL_P;
                state_next = S_MI;
            end
            S_MI:
            begin
                uop        = UOP_MUL_I;
                state_next = S_MD;
            end
            S_MD:
            begin
                uop        = UOP_MUL_D;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                uop        = UOP_MUL_ACC;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                uop        = UOP_MAG_GO;
                state_next = S_MAG_W;
            end
            S_MAG_W:
            begin
                if (status.div_done)
                begin
                    uop        = UOP_DUTY_END;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    uop        = UOP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end else
        begin
            state_reg <= state_next;
        end
    end

    assign tick_ready = (state_reg == S_IDLE);
    assign cmd.uop    = uop;

endmodule

`default_nettype wire

// ===== rtl/core/servo_position_pid_top.sv =====
// Top level of the servo position PID controller.
//
//   channel  dir  fields                                      handshake
//   tick     in   pulse_width[14:0], sensor_sample[11:0]      valid/ready
//   drive    out  forward_duty[7:0], reverse_duty[7:0],       valid/ready
//                 sensor_fault
//   cfg      in   cfg_index[2:0], cfg_data[15:0]              cfg_we, no stall
//
// One tick item at a time. Nearly all of the work from acceptance to the result
// register is the shared radix-16 constant divider (target, position, two
// filters, integral and duty scaling), four quotient bits per cycle; a sensor
// out of limits skips the integral, multiply and duty steps.
// The result sits in an output register, so the next tick is taken while
// the drive side stalls. Reset clears the filters, integral and last error
// and loads the register defaults.
`default_nettype none

module servo_position_pid_top (
    input  logic                              clk,
    input  logic                              rst_n,
    svpid_tick_if.sink                        tick,
    svpid_drive_if.source                     drive,
    input  logic                              cfg_we,
    input  logic [svpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svpid_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import svpid_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    svpid_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .status     (status),
        .cmd        (cmd)
    );

    svpid_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .pulse_width   (tick.pulse_width),
        .sensor_sample (tick.sensor_sample),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .drive_ready   (drive.ready),
        .drive_valid   (drive.valid),
        .forward_duty  (drive.forward_duty),
        .reverse_duty  (drive.reverse_duty),
        .sensor_fault  (drive.sensor_fault)
    );

endmodule

`default_nettype wire

// ===== sim/svpid_drive_checker.sv =====
// Drive result predictor and scoreboard for the servo position PID block.

module svpid_drive_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    svpid_tick_if                             tick,
    svpid_drive_if                            drive,
    input  logic                              cfg_we,
    input  logic [svpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svpid_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                mismatches,
    output int                                pending,
    output int                                drives_checked,
    output int                                faults_seen,
    output int                                forward_seen,
    output int                                reverse_seen
);
    import svpid_pkg::*;

    localparam longint UNIT       = 64'sd1 <<< FRAC_BITS;
    localparam longint SAMPLE_MAX = (64'sd1 <<< ADC_BITS) - 1;
    localparam longint S32_MAX    = 64'sd2147483647;
    localparam longint S32_MIN    = -64'sd2147483648;
    localparam longint ISUM_LIMIT = 100 * UNIT;
    localparam longint MAG_LIMIT  = 1000;

    typedef struct packed {
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
        logic              fault;
    } drive_item_t;

    // Register copies
    logic [GAIN_W-1:0]  kp, ki, kd;
    logic [DUTY_W-1:0]  duty_min, duty_max;
    logic [LIMIT_W-1:0] lim_lo, lim_hi;

    // Controller state, Q16.16 held in 64 bit
    longint tgt_avg, pos_avg, err_integral, err_last;

    drive_item_t drive_due[$];
    int          bad_count, checked, nfault, nfwd, nrev;

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // 0.9/0.1 exponential filter, truncating toward zero
    function automatic longint ema_step(input longint s, input longint x);
        return clamp32((9 * s + x * UNIT) / 10);
    endfunction

    // One control tick: update the filters and PID state, return the drive item
    function automatic drive_item_t servo_tick_drive(input logic [PW_W-1:0] pw,
                                                     input logic [SAMP_W-1:0] samp);
        longint            cmd, raw, where_at, e, rate, acc, mag, scaled;
        logic [DUTY_W-1:0] duty;
        drive_item_t       res;
        cmd = 0;
        if (pw > 900 && pw < 2100)
            cmd = (longint'(pw) - 1000) * 200 / 1000 - 100;
        raw = longint'(samp);
        if (raw > SAMPLE_MAX)
            raw = SAMPLE_MAX;
        where_at = raw * 200 / SAMPLE_MAX - 100;
        tgt_avg = ema_step(tgt_avg, cmd);
        pos_avg = ema_step(pos_avg, where_at);

        // deadband below one unit also clears the integral
        e = clamp32(tgt_avg - pos_avg);
        if (e > -UNIT && e < UNIT)
        begin
            e = 0;
            err_integral = 0;
        end

        res = '0;
        if (samp < lim_lo || samp > lim_hi)
        begin
            err_integral = 0;
            err_last = e;
            res.fault = 1'b1;
            return res;
        end

        err_integral += e / 50;
        if (err_integral > ISUM_LIMIT)
            err_integral = ISUM_LIMIT;
        if (err_integral < -ISUM_LIMIT)
            err_integral = -ISUM_LIMIT;
        rate = (e - err_last) * 50;
        acc = longint'(kp) * e + longint'(ki) * err_integral + longint'(kd) * rate;
        err_last = e;

        // |acc| to duty, then floor / ceiling on nonzero values
        mag = (acc < 0) ? -acc : acc;
        mag = mag >> (FRAC_BITS + 12);
        if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
        scaled = mag * 255 / 100;
        duty = '0;
        if (scaled > 0)
        begin
            if (scaled < longint'(duty_min))
                duty = duty_min;
            else if (scaled > longint'(duty_max))
                duty = duty_max;
            else
                duty = DUTY_W'(scaled);
        end
        res.fwd = (acc > 0) ? duty : '0;
        res.rev = (acc < 0) ? duty : '0;
        return res;
    endfunction

    // Track register writes, predict on each accepted tick, check each drive item
    always @(posedge clk or negedge rst_n)
    begin
        drive_item_t seen;
        drive_item_t want;
        if (!rst_n)
        begin
            kp = GAIN_P_RST;
            ki = GAIN_I_RST;
            kd = GAIN_D_RST;
            duty_min = FLOOR_RST;
            duty_max = CEIL_RST;
            lim_lo = LOW_RST;
            lim_hi = HIGH_RST;
            tgt_avg = 0;
            pos_avg = 0;
            err_integral = 0;
            err_last = 0;
            drive_due.delete();
            bad_count = 0;
            checked = 0;
            nfault = 0;
            nfwd = 0;
            nrev = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN_P:      kp = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:      ki = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:      kd = cfg_data[GAIN_W-1:0];
                    CFG_DRIVE_FLOOR: duty_min = cfg_data[DUTY_W-1:0];
                    CFG_DRIVE_CEIL:  duty_max = cfg_data[DUTY_W-1:0];
                    CFG_SENSOR_LOW:  lim_lo = cfg_data[LIMIT_W-1:0];
                    CFG_SENSOR_HIGH: lim_hi = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (tick.valid && tick.ready)
                drive_due.push_back(servo_tick_drive(tick.pulse_width, tick.sensor_sample));

            if (drive.valid && drive.ready)
            begin
                seen.fwd = drive.forward_duty;
                seen.rev = drive.reverse_duty;
                seen.fault = drive.sensor_fault;
                checked++;
                if (seen.fault === 1'b1)
                    nfault++;
                if (seen.fwd != 0)
                    nfwd++;
                if (seen.rev != 0)
                    nrev++;
                if (drive_due.size() == 0)
                begin
                    $display("%0t: drive item with none expected: fwd %0d rev %0d fault %0b",
                             $time, seen.fwd, seen.rev, seen.fault);
                    bad_count++;
                end
                else
                begin
                    want = drive_due.pop_front();
                    if (seen.fwd !== want.fwd)
                    begin
                        $display("%0t: forward_duty expected %0d, got %0d",
                                 $time, want.fwd, seen.fwd);
                        bad_count++;
                    end
                    if (seen.rev !== want.rev)
                    begin
                        $display("%0t: reverse_duty expected %0d, got %0d",
                                 $time, want.rev, seen.rev);
                        bad_count++;
                    end
                    if (seen.fault !== want.fault)
                    begin
                        $display("%0t: sensor_fault expected %0b, got %0b",
                                 $time, want.fault, seen.fault);
                        bad_count++;
                    end
                end
            end
        end

        // outputs change after the edge so the stimulus side reads them cleanly
        mismatches <= bad_count;
        pending <= drive_due.size();
        drives_checked <= checked;
        faults_seen <= nfault;
        forward_seen <= nfwd;
        reverse_seen <= nrev;
    end

endmodule

// ===== sim/testbench.sv =====
// Stimulus, flow control and verdict for the servo position PID block.

module testbench;
    import svpid_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady;

    int mismatches, pending, drives_checked, faults_seen, forward_seen, reverse_seen;
    int cycle_count;
    int pos_track;

    svpid_tick_if  tick();
    svpid_drive_if drive();

    servo_position_pid_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .drive     (drive),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    svpid_drive_checker i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .drive          (drive),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .drives_checked (drives_checked),
        .faults_seen    (faults_seen),
        .forward_seen   (forward_seen),
        .reverse_seen   (reverse_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Idle length: mostly short, a few long enough to span a whole tick
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 90)
            return $urandom_range(3, 8);
        if (r < 97)
            return $urandom_range(9, 30);
        return $urandom_range(40, 120);
    endfunction

    function automatic int tick_gap();
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return idle_span();
    endfunction

    // Drive side back-pressure
    initial
    begin
        int hold;
        drive.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                drive.ready <= 1'b0;
            else if (hold > 0)
            begin
                drive.ready <= 1'b0;
                hold--;
            end
            else
            begin
                drive.ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 30)
                    hold = idle_span();
            end
        end
    end

    // Present one tick item after an optional gap; returns at its acceptance edge
    task automatic push_tick(input logic [PW_W-1:0] pw, input logic [SAMP_W-1:0] samp,
                             input int gap);
        if (gap > 0)
        begin
            tick.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick.valid <= 1'b1;
        tick.pulse_width <= pw;
        tick.sensor_sample <= samp;
        @(posedge clk);
        while (!tick.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted drive item has arrived
    task automatic drain_drives();
        tick.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Full register set, written back to back while the block is idle
    task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                 input logic [GAIN_W-1:0] kd,
                                 input logic [DUTY_W-1:0] lo_duty,
                                 input logic [DUTY_W-1:0] hi_duty,
                                 input logic [LIMIT_W-1:0] lo_lim,
                                 input logic [LIMIT_W-1:0] hi_lim);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_DRIVE_FLOOR, lo_duty);
        write_reg(CFG_DRIVE_CEIL, hi_duty);
        write_reg(CFG_SENSOR_LOW, lo_lim);
        write_reg(CFG_SENSOR_HIGH, hi_lim);
        cfg_we <= 1'b0;
    endtask

    // Held commands with a sensor that follows them, plus glitches and noise
    task automatic run_phase(input int count);
        int              sent, run_len, aim, r;
        logic [PW_W-1:0] pw;
        logic [SAMP_W-1:0] samp;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                pw = PW_W'($urandom_range(901, 2099));
            else if (r < 75)
            begin
                case ($urandom_range(0, 5))
                    0: pw = PW_W'(900);
                    1: pw = PW_W'(901);
                    2: pw = PW_W'(2099);
                    3: pw = PW_W'(2100);
                    4: pw = PW_W'(1000);
                    default: pw = PW_W'(2000);
                endcase
            end
            else if (r < 85)
                pw = '0;
            else
                pw = PW_W'($urandom_range(0, 30000));
            aim = (pw > 900 && pw < 2100) ? (int'(pw) - 900) * 4095 / 1200 : 2048;
            run_len = $urandom_range(3, 25);
            steady <= ($urandom_range(0, 7) == 0);
            for (int k = 0; k < run_len && sent < count; k++)
            begin
                pos_track += (aim - pos_track) / 4 + int'($urandom_range(0, 40)) - 20;
                if (pos_track < 0)
                    pos_track = 0;
                if (pos_track > 4095)
                    pos_track = 4095;
                if ($urandom_range(0, 99) < 8)
                    samp = SAMP_W'($urandom_range(0, 4095));
                else
                    samp = SAMP_W'(pos_track);
                push_tick(pw, samp, tick_gap());
                sent++;
                if ($urandom_range(0, 99) < 2)
                    drain_drives();
            end
        end
        drain_drives();
    endtask

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d drive items outstanding",
                 cycle_count, pending);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        tick.valid = 1'b0;
        tick.pulse_width = '0;
        tick.sensor_sample = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_GAIN_P;
        cfg_data = '0;
        steady = 1'b0;
        pos_track = 2048;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: command edges, zero output and sensor limits at reset settings
        push_tick(PW_W'(1500), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(0), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(900), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(901), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(2099), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(2100), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(30000), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(1000), SAMP_W'(0), tick_gap());
        push_tick(PW_W'(2000), SAMP_W'(9), tick_gap());
        push_tick(PW_W'(2000), SAMP_W'(10), tick_gap());
        push_tick(PW_W'(2000), SAMP_W'(4080), tick_gap());
        push_tick(PW_W'(2000), SAMP_W'(4081), tick_gap());
        push_tick(PW_W'(2099), SAMP_W'(4095), tick_gap());
        push_tick(PW_W'(1500), SAMP_W'(2048), tick_gap());
        drain_drives();

        // Directed: saturated output with the floor above the ceiling
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd200, 8'd50, 12'd0, 12'd4095);
        push_tick(PW_W'(2099), SAMP_W'(0), tick_gap());
        push_tick(PW_W'(2099), SAMP_W'(0), tick_gap());
        push_tick(PW_W'(901), SAMP_W'(4095), tick_gap());
        push_tick(PW_W'(900), SAMP_W'(4095), tick_gap());
        push_tick(PW_W'(1500), SAMP_W'(2048), tick_gap());
        push_tick(PW_W'(1500), SAMP_W'(2047), tick_gap());
        push_tick(PW_W'(1500), SAMP_W'(2048), tick_gap());
        drain_drives();

        // Random phases over a spread of settings
        load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, FLOOR_RST, CEIL_RST,
                      LOW_RST, HIGH_RST);
        run_phase(100);
        load_settings('0, '0, '0, '0, '0, '0, 12'd4095);
        run_phase(40);
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 12'd4095, 12'd0);
        run_phase(30);
        load_settings(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
                      GAIN_W'($urandom_range(0, 65535)), DUTY_W'($urandom_range(0, 255)),
                      DUTY_W'($urandom_range(0, 255)), LIMIT_W'($urandom_range(0, 200)),
                      LIMIT_W'($urandom_range(3800, 4095)));
        run_phase(120);
        load_settings(16'd4096, 16'd40, 16'd600, 8'd30, 8'd220, 12'd200, 12'd3900);
        run_phase(130);
        load_settings(GAIN_W'($urandom_range(0, 16384)), GAIN_W'($urandom_range(0, 4096)),
                      GAIN_W'($urandom_range(0, 4096)), DUTY_W'($urandom_range(0, 255)),
                      DUTY_W'($urandom_range(0, 255)), '0, 12'd4095);
        run_phase(120);

        // Let anything late show up
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d drive items: %0d sensor faults, %0d forward, %0d reverse",
                 drives_checked, faults_seen, forward_seen, reverse_seen);
        $display("%0d mismatches, %0d drive items never arrived", mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/svpid_pkg.sv
rtl/core/svpid_tick_if.sv
rtl/core/svpid_drive_if.sv
rtl/core/svpid_cdiv.sv
rtl/core/svpid_datapath.sv
rtl/core/svpid_ctrl.sv
rtl/core/servo_position_pid_top.sv
sim/svpid_drive_checker.sv
sim/testbench.sv
